// File: sv/tdrp_pkg.sv
// ----------------------------------------------------------------------------
// tdrp_pkg
// Shared types and character codes for the tagged decimal reading parser.
// ----------------------------------------------------------------------------
package tdrp_pkg;

	// default field length in bytes after a tag
	localparam int MAX_CHARS_DEF = 15;

	// character codes
	localparam logic [7:0] CHAR_TAG_TEMP = 8'h54;
	localparam logic [7:0] CHAR_TAG_PRES = 8'h50;
	localparam logic [7:0] CHAR_CR       = 8'h0D;
	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_PLUS     = 8'h2B;
	localparam logic [7:0] CHAR_MINUS    = 8'h2D;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_NINE     = 8'h39;

	// reading kind on the output
	localparam logic KIND_OUT_TEMP = 1'b0;
	localparam logic KIND_OUT_PRES = 1'b1;

	// which field is open
	typedef enum logic [2:0] {
		FK_NONE = 3'b001,
		FK_TEMP = 3'b010,
		FK_PRES = 3'b100
	} field_kind_t;

	// conversion phase
	typedef enum logic [3:0] {
		PH_SPACE = 4'b0001,
		PH_SIGN  = 4'b0010,
		PH_DIGIT = 4'b0100,
		PH_DONE  = 4'b1000
	} scan_phase_t;

endpackage

// File: sv/tagged_decimal_reading_parser_unit.sv
// ----------------------------------------------------------------------------
// tagged_decimal_reading_parser_unit
// Parses tagged ASCII readings ('T' temperature, 'P' pressure) into signed
// values, one received byte per beat, emitting a reading on carriage return.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | rx_byte[7:0]
//  out     | out_valid/out_stall | reading_kind, reading_value[31:0] signed
//
//  one byte per cycle sustained while out_stall is low; a beat reaches the result
//  via the input register, then the conversion step into the result register
//  the conversion step is one times-ten shift-add and one negate of 32 bits
//  reset clears the open field, the collection state and both valid flags
//  out_stall holds the result register; the input register keeps taking a
//  beat while empty, so in_stall rises only when both stages are full
// ----------------------------------------------------------------------------
module tagged_decimal_reading_parser_unit
	import tdrp_pkg::*;
#(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               reading_kind,
	output logic signed [31:0] reading_value
);

	localparam int CNT_W = $clog2(MAX_CHARS + 1);

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// collection state
	field_kind_t      kind_q;
	logic [CNT_W-1:0] cnt_q;
	scan_phase_t      phase_q;
	logic             neg_q;
	logic [31:0]      acc_q;

	// result register
	logic        res_valid_q;
	logic        res_kind_q;
	logic [31:0] res_value_q;

	logic adv;
	logic accept;
	logic step;

	// decoded byte and next state
	logic        is_tag;
	logic        is_cr;
	logic        is_digit;
	logic        emit;
	field_kind_t kind_d;
	logic [CNT_W-1:0] cnt_d;
	scan_phase_t phase_d;
	logic        neg_d;
	logic [31:0] acc_d;
	logic [31:0] signed_val;
	logic [31:0] value_d;

	// handshake
	assign adv      = !res_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign step     = valid_s1 && adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// byte classification
	always_comb begin
		is_tag   = (byte_s1 == CHAR_TAG_TEMP) || (byte_s1 == CHAR_TAG_PRES);
		is_cr    = (byte_s1 == CHAR_CR);
		is_digit = byte_s1 inside {[CHAR_ZERO:CHAR_NINE]};
	end

	// signed value and wrap to the width of the kind
	always_comb begin
		signed_val = neg_q ? (32'd0 - acc_q) : acc_q;
		if (kind_q == FK_TEMP) begin
			value_d = {{16{signed_val[15]}}, signed_val[15:0]};
		end else begin
			value_d = signed_val;
		end
	end

	// collection update
	always_comb begin
		kind_d  = kind_q;
		cnt_d   = cnt_q;
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		emit    = 1'b0;
		if (is_tag) begin
			kind_d  = (byte_s1 == CHAR_TAG_TEMP) ? FK_TEMP : FK_PRES;
			cnt_d   = '0;
			phase_d = PH_SPACE;
			neg_d   = 1'b0;
			acc_d   = '0;
		end else if (kind_q != FK_NONE) begin
			if (is_cr) begin
				emit    = 1'b1;
				cnt_d   = '0;
				phase_d = PH_SPACE;
				neg_d   = 1'b0;
				acc_d   = '0;
			end else if (cnt_q < CNT_W'(MAX_CHARS)) begin
				cnt_d = cnt_q + 1'b1;
				if (phase_q != PH_DONE) begin
					if (is_digit) begin
						acc_d   = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0}
						        + {28'd0, byte_s1[3:0]};
						phase_d = PH_DIGIT;
					end else if (phase_q == PH_SPACE && byte_s1 == CHAR_SPACE) begin
						phase_d = PH_SPACE;
					end else if (phase_q == PH_SPACE &&
					             (byte_s1 == CHAR_PLUS || byte_s1 == CHAR_MINUS)) begin
						neg_d   = (byte_s1 == CHAR_MINUS);
						phase_d = PH_SIGN;
					end else begin
						phase_d = PH_DONE;
					end
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= FK_NONE;
			cnt_q   <= '0;
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (step) begin
			kind_q  <= kind_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_kind_q  <= (kind_q == FK_TEMP) ? KIND_OUT_TEMP : KIND_OUT_PRES;
			res_value_q <= value_d;
		end
	end

	assign out_valid     = res_valid_q;
	assign reading_kind  = res_kind_q;
	assign reading_value = signed'(res_value_q);

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CHARS))
		else $error("char count past field length");

	a_temp_sext: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reading_kind == KIND_OUT_TEMP)
		|-> (res_value_q[31:16] == {16{res_value_q[15]}}))
		else $error("temperature reading not sign extended");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && res_valid_q))
		else $error("input stalled with a free stage");

	a_tag_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_tag) |=> (acc_q == '0 && cnt_q == '0 && !neg_q))
		else $error("tag did not restart collection");

	a_cr_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_cr && kind_q != FK_NONE) |=> out_valid)
		else $error("carriage return in open field gave no reading");

endmodule
